[hdl/assert_macros.svh]
// Assertion macros for the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define CFAE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cfae assertion failed");

// Next-cycle implication, off while reset is held.
`define CFAE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cfae assertion failed");

// Next-cycle implication that also holds through reset.
`define CFAE_ASSERT_NXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("cfae assertion failed");

`endif

[hdl/cfae_pkg.sv]
// Types, constants and the CRC step shared by the CRC-16 frame block.
package cfae_pkg;

  localparam int MaxFrame   = 256;
  localparam int CountLimit = 511;
  // received frame overflows when a byte arrives with byte_count already at this
  localparam int LenLimit   = (MaxFrame < CountLimit) ? MaxFrame : CountLimit;
  localparam logic [15:0] CrcPoly = 16'h1021;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_CRC     = 2'd1,
    KIND_STATUS  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_GOOD          = 3'd0,
    ST_CRC_ERROR     = 3'd1,
    ST_SHORT         = 3'd2,
    ST_TOO_LONG      = 3'd3,
    ST_NOT_LISTENING = 3'd4
  } status_t;

  typedef struct packed {
    logic [7:0] len;
    status_t    status;
    kind_t      kind;
    logic [7:0] data;
  } item_t;

  // up to three results caused by one input byte
  typedef struct packed {
    logic [1:0]       cnt;
    item_t [2:0]      items;
  } bundle_t;

  typedef struct packed {
    logic    valid;
    bundle_t bundle;
  } push_t;

  // CRC-16/XMODEM, one byte, MSB first
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) c = {c[14:0], 1'b0} ^ CrcPoly;
      else       c = {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

[hdl/cfae_core.sv]
// Frame state, CRC accumulation and result generation for one accepted byte.
module cfae_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic                op,
  input  logic [7:0]          data,
  input  logic                last,
  input  logic                cfg_we,
  input  logic                cfg_data,
  output cfae_pkg::push_t     push
);

  logic [15:0] crc_r, crc_nxt;
  logic [8:0]  cnt_r, cnt_nxt;
  logic        mode_r, mode_nxt;
  logic        ovl_r, ovl_nxt;
  logic        listen_r;
  logic [7:0]  hold0_r, hold0_nxt, hold1_r, hold1_nxt;

  logic             mode;
  logic [7:0]       crc_in;
  logic [15:0]      crc_f;
  logic [8:0]       len9;
  cfae_pkg::item_t  st_item;
  cfae_pkg::bundle_t bnd;

  assign mode   = (cnt_r == 9'd0 && !ovl_r) ? op : mode_r;
  assign crc_in = mode ? data : hold0_r;
  assign crc_f  = cfae_pkg::crc_fold(crc_r, crc_in);

  always_comb begin
    crc_nxt   = crc_r;
    cnt_nxt   = cnt_r;
    mode_nxt  = mode;
    ovl_nxt   = ovl_r;
    hold0_nxt = hold0_r;
    hold1_nxt = hold1_r;
    bnd       = '0;
    st_item   = '0;
    len9      = '0;
    if (mode) begin
      bnd.items[0].data = data;
      bnd.items[0].kind = cfae_pkg::KIND_PAYLOAD;
      bnd.cnt           = 2'd1;
      crc_nxt           = crc_f;
      if (cnt_r < 9'(cfae_pkg::CountLimit)) cnt_nxt = cnt_r + 9'd1;
      if (last) begin
        bnd.items[1].data = crc_f[7:0];
        bnd.items[1].kind = cfae_pkg::KIND_CRC;
        bnd.items[2].data = crc_f[15:8];
        bnd.items[2].kind = cfae_pkg::KIND_CRC;
        bnd.cnt           = 2'd3;
      end
    end else begin
      if (!ovl_r) begin
        if (cnt_r >= 9'(cfae_pkg::LenLimit)) begin
          ovl_nxt = 1'b1;
        end else begin
          if (cnt_r >= 9'd2) begin
            bnd.items[0].data = hold0_r;
            bnd.items[0].kind = cfae_pkg::KIND_PAYLOAD;
            bnd.cnt           = 2'd1;
            crc_nxt           = crc_f;
            hold0_nxt         = hold1_r;
            hold1_nxt         = data;
          end else if (cnt_r[0]) begin
            hold1_nxt = data;
          end else begin
            hold0_nxt = data;
          end
          cnt_nxt = cnt_r + 9'd1;
        end
      end
      if (last) begin
        st_item.kind = cfae_pkg::KIND_STATUS;
        if (ovl_nxt) begin
          st_item.status = cfae_pkg::ST_TOO_LONG;
        end else if (cnt_nxt < 9'd2) begin
          st_item.status = cfae_pkg::ST_SHORT;
        end else begin
          len9        = cnt_nxt - 9'd2;
          st_item.len = (len9 > 9'd255) ? 8'hFF : len9[7:0];
          if ({hold1_nxt, hold0_nxt} != crc_nxt) st_item.status = cfae_pkg::ST_CRC_ERROR;
          else if (!listen_r)                    st_item.status = cfae_pkg::ST_NOT_LISTENING;
          else                                   st_item.status = cfae_pkg::ST_GOOD;
        end
        if (bnd.cnt == 2'd1) begin
          bnd.items[1] = st_item;
          bnd.cnt      = 2'd2;
        end else begin
          bnd.items[0] = st_item;
          bnd.cnt      = 2'd1;
        end
      end
    end
    // frame end returns the CRC, count, mode and overflow state to idle
    if (last) begin
      crc_nxt  = '0;
      cnt_nxt  = '0;
      mode_nxt = 1'b0;
      ovl_nxt  = 1'b0;
    end
  end

  assign push.valid  = accept && (bnd.cnt != 2'd0);
  assign push.bundle = bnd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r    <= '0;
      cnt_r    <= '0;
      mode_r   <= 1'b0;
      ovl_r    <= 1'b0;
      listen_r <= 1'b1;
    end else begin
      if (accept) begin
        crc_r  <= crc_nxt;
        cnt_r  <= cnt_nxt;
        mode_r <= mode_nxt;
        ovl_r  <= ovl_nxt;
      end
      if (cfg_we) listen_r <= cfg_data;
    end
  end

  // held bytes are only read after both were written in the frame
  always_ff @(posedge clk) begin
    if (accept) begin
      hold0_r <= hold0_nxt;
      hold1_r <= hold1_nxt;
    end
  end

endmodule

[hdl/cfae_outq.sv]
// Two-entry result queue that serializes each bundle onto the output channel.
module cfae_outq (
  input  logic             clk,
  input  logic             rst_n,
  input  cfae_pkg::push_t  push,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output cfae_pkg::item_t  out_item,
  output logic             out_last
);

  cfae_pkg::bundle_t q_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic [1:0] sub_r;
  cfae_pkg::bundle_t head;
  logic       pop, xfer;

  assign head      = q_r[rd_ptr_r];
  assign out_valid = (cnt_r != 2'd0);
  assign in_ready  = (cnt_r != 2'd2);
  assign out_last  = (sub_r == head.cnt - 2'd1);
  assign xfer      = out_valid && out_ready;
  assign pop       = xfer && out_last;

  always_comb begin
    case (sub_r)
      2'd0:    out_item = head.items[0];
      2'd1:    out_item = head.items[1];
      2'd2:    out_item = head.items[2];
      default: out_item = '0;
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (push.valid && !pop) cnt_nxt = cnt_r + 2'd1;
    else if (!push.valid && pop) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
      sub_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push.valid) wr_ptr_r <= ~wr_ptr_r;
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
        sub_r    <= '0;
      end else if (xfer) begin
        sub_r <= sub_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) q_r[wr_ptr_r] <= push.bundle;
  end

endmodule

[hdl/crc16_frame_append_and_check_top.sv]
// Top level of the CRC-16 frame append and check block.
//
//  channel | direction | tdata / data              | tuser        | tlast
//  --------+-----------+---------------------------+--------------+-----------
//  in_     | slave     | [7:0] data_byte           | [0] op       | last_byte
//  out_    | master    | [7:0] out_byte,           | [1:0] kind   | end_of_run
//          |           | [10:8] frame_status,      |              |
//          |           | [18:11] payload_length    |              |
//  cfg_    | slave     | [0] listening             | -            | -
//
// One input byte per cycle while in_tready is high; each byte's results are
// registered in the result queue. A transmit frame end adds two CRC results to
// its payload result; the two-bundle result queue sets when in_tready drops.
// Reset is synchronous, active low, and leaves listening at 1 and no frame open.
// Output stalls back up into the queue; in_tready falls only when it is full.
// cfg_ready is always high; write it only while the block is idle.
module crc16_frame_append_and_check_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic [0:0]  in_tuser,   // [0] op
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] out_byte, [10:8] frame_status,
                                  // [18:11] payload_length, [23:19] zero
  output logic [1:0]  out_tuser,  // [1:0] item_kind
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_data    // [0] listening
);

  cfae_pkg::push_t push;
  cfae_pkg::item_t item;
  logic            accept;

  assign accept    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  cfae_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .op       (in_tuser[0]),
    .data     (in_tdata),
    .last     (in_tlast),
    .cfg_we   (cfg_valid),
    .cfg_data (cfg_data[0]),
    .push     (push)
  );

  cfae_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_item  (item),
    .out_last  (out_tlast)
  );

  assign out_tdata = {5'b0, item.len, item.status, item.data};
  assign out_tuser = item.kind;

endmodule

[hdl/cfae_checker.sv]
// Port-level checks for the CRC-16 frame block, bound to the top level.
`include "assert_macros.svh"

module cfae_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  `CFAE_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
                   out_tvalid && $stable(out_tdata))
  `CFAE_ASSERT_NXT_ALWAYS(a_reset_empty, clk, !rst_n, !out_tvalid)
  `CFAE_ASSERT_IMP(a_stall_backed, clk, rst_n, !in_tready, out_tvalid)
  `CFAE_ASSERT_IMP(a_status_ends, clk, rst_n, out_tvalid && out_tuser == cfae_pkg::KIND_STATUS,
                   out_tlast && out_tdata[7:0] == 8'd0)
  `CFAE_ASSERT_IMP(a_kind_legal, clk, rst_n, out_tvalid, out_tuser != 2'd3)

endmodule

bind crc16_frame_append_and_check_top cfae_checker u_cfae_checker (.*);

[test/tb_crc16_frame_append_and_check_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the CRC-16 frame append and check block.
module tb_crc16_frame_append_and_check_top;

  // Generous ceiling: about 360 bytes, each with the longest input gap, three
  // results each behind the longest output stall, then taken several times over.
  localparam int unsigned CycleLimit = 150_000;
  localparam int DrainCycles = 8;     // settle time after the last expected result is seen
  localparam int MaxPrinted = 20;     // mismatch reports printed before going quiet

  // one byte on the input stream
  typedef struct packed {
    logic       op;
    logic [7:0] data;
    logic       last;
  } frame_byte_t;

  // one result as the output stream should carry it
  typedef struct packed {
    logic [7:0]        data;
    cfae_pkg::kind_t   kind;
    cfae_pkg::status_t st;
    logic [7:0]        len;
    logic              eor;
  } result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // [7:0] data_byte
  logic [0:0]  in_tuser = '0;   // [0] op
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;       // [7:0] byte, [10:8] status, [18:11] length, [23:19] zero
  logic [1:0]  out_tuser;       // [1:0] kind
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_data = '0;   // [0] listening

  crc16_frame_append_and_check_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Stimulus and scoreboard storage
  // ---------------------------------------------------------------------------
  frame_byte_t pending_bytes[$];     // bytes waiting for the driver
  result_t     expected_results[$];  // predicted results, oldest first
  logic [7:0]  payload_buf[$];       // scratch payload for the frame builders

  // predictor's copy of the block state
  logic [15:0] run_crc;
  logic [7:0]  held [2];     // two newest receive bytes, the candidate CRC
  logic [8:0]  taken;        // bytes of the open frame, 0 between frames
  logic        tx_open;
  logic        too_long;
  logic        listen_en;

  int errors = 0;
  int bytes_sent = 0;
  int results_seen = 0;
  int cfg_writes = 0;
  int tx_frames = 0;
  int status_seen [5];
  int unsigned cycle_count = 0;

  // CRC-16/XMODEM, one byte folded in MSB first, bit-serial form
  function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] d);
    logic [15:0] r;
    logic        fb;
    r = c;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ d[i];
      r = {r[14:0], 1'b0};
      if (fb) r = r ^ cfae_pkg::CrcPoly;
    end
    return r;
  endfunction

  function automatic void clear_frame();
    run_crc  = '0;
    held[0]  = '0;
    held[1]  = '0;
    taken    = '0;
    tx_open  = 1'b0;
    too_long = 1'b0;
  endfunction

  // Works out the results of one accepted byte and queues them.
  task automatic predict_frame_byte(input frame_byte_t b);
    result_t           res [3];
    int                n;
    int                nxt;
    cfae_pkg::status_t st;
    logic [7:0]        len;
    logic [15:0]       theirs;
    n = 0;
    // op is only looked at on the first byte of a frame
    if (taken == 0 && !too_long) tx_open = b.op;
    if (tx_open) begin
      res[n] = '{b.data, cfae_pkg::KIND_PAYLOAD, cfae_pkg::ST_GOOD, 8'd0, 1'b0};
      n++;
      run_crc = crc_step(run_crc, b.data);
      if (taken < cfae_pkg::CountLimit) taken++;   // transmit length saturates
      if (b.last) begin
        res[n] = '{run_crc[7:0], cfae_pkg::KIND_CRC, cfae_pkg::ST_GOOD, 8'd0, 1'b0};
        n++;
        res[n] = '{run_crc[15:8], cfae_pkg::KIND_CRC, cfae_pkg::ST_GOOD, 8'd0, 1'b0};
        n++;
        tx_frames++;
        clear_frame();
      end
    end else begin
      if (!too_long) begin
        nxt = int'(taken) + 1;
        if (nxt > cfae_pkg::MaxFrame || nxt > cfae_pkg::CountLimit) begin
          // overflow: drop the held bytes, release nothing more
          too_long = 1'b1;
          held[0]  = '0;
          held[1]  = '0;
        end else begin
          if (taken >= 2) begin
            res[n] = '{held[0], cfae_pkg::KIND_PAYLOAD, cfae_pkg::ST_GOOD, 8'd0, 1'b0};
            n++;
            run_crc = crc_step(run_crc, held[0]);
            held[0] = held[1];
            held[1] = b.data;
          end else begin
            held[taken[0]] = b.data;
          end
          taken = nxt[8:0];
        end
      end
      if (b.last) begin
        len = 8'd0;
        if (too_long) begin
          st = cfae_pkg::ST_TOO_LONG;
        end else if (taken < 2) begin
          st = cfae_pkg::ST_SHORT;
        end else begin
          theirs = {held[1], held[0]};   // low byte came first
          len = (taken > 9'd257) ? 8'hFF : 8'(taken - 9'd2);
          if (theirs != run_crc) st = cfae_pkg::ST_CRC_ERROR;
          else if (!listen_en)   st = cfae_pkg::ST_NOT_LISTENING;
          else                   st = cfae_pkg::ST_GOOD;
        end
        res[n] = '{8'd0, cfae_pkg::KIND_STATUS, st, len, 1'b0};
        n++;
        status_seen[st]++;
        clear_frame();
      end
    end
    for (int i = 0; i < n; i++) begin
      res[i].eor = (i == n - 1);
      expected_results.push_back(res[i]);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Input driver: one byte per transfer, random gap after each transfer.
  // Gaps come in stretches; in_idle_on flips now and then so that some
  // stretches run back to back at full rate.
  // ---------------------------------------------------------------------------
  frame_byte_t in_cur;
  int          in_gap = 0;
  logic        in_idle_on = 1'b1;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_frame_byte(in_cur);
        bytes_sent++;
        if ($urandom_range(0, 39) == 0) in_idle_on = !in_idle_on;
        in_gap = in_idle_on ? int'($urandom_range(0, 16)) : 0;
      end
      if (in_tvalid && !in_tready) begin
        // byte still offered, hold it
      end else if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (pending_bytes.size() > 0) begin
        in_cur = pending_bytes.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= in_cur.data;
        in_tuser  <= in_cur.op;
        in_tlast  <= in_cur.last;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output monitor: compares every transfer with the oldest prediction, then
  // stalls tready for a random count, again in stretches.
  // ---------------------------------------------------------------------------
  int   out_stall = 0;
  logic out_idle_on = 1'b1;

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= MaxPrinted)
            $display("%0t: result with nothing expected: tdata=%h tuser=%h tlast=%b",
                     $time, out_tdata, out_tuser, out_tlast);
        end else begin
          want = expected_results.pop_front();
          if (out_tdata !== {5'd0, want.len, want.st, want.data} ||
              out_tuser !== want.kind || out_tlast !== want.eor) begin
            errors++;
            if (errors <= MaxPrinted)
              $display("%0t: mismatch: expected byte=%h kind=%0d status=%0d len=%0d last=%b,",
                       $time, want.data, want.kind, want.st, want.len, want.eor,
                       " actual byte=%h kind=%0d status=%0d len=%0d last=%b pad=%h",
                       out_tdata[7:0], out_tuser, out_tdata[10:8], out_tdata[18:11],
                       out_tlast, out_tdata[23:19]);
          end
        end
        if ($urandom_range(0, 39) == 0) out_idle_on = !out_idle_on;
        out_stall = out_idle_on ? int'($urandom_range(0, 16)) : 0;
      end
      if (out_stall > 0) begin
        out_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // run ceiling
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: timeout, %0d results still expected", $time, expected_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Frame builders
  // ---------------------------------------------------------------------------
  task automatic push_byte(input logic op, input logic [7:0] d, input logic last);
    frame_byte_t b;
    b.op   = op;
    b.data = d;
    b.last = last;
    pending_bytes.push_back(b);
  endtask

  task automatic fill_payload(input int n);
    payload_buf.delete();
    for (int i = 0; i < n; i++) payload_buf.push_back(8'($urandom_range(0, 255)));
  endtask

  // receive frame: payload then CRC low, high; corrupt flips some CRC bits.
  // op after the first byte is don't-care, so it is randomized.
  task automatic add_rx_frame(input logic corrupt);
    logic [15:0] c;
    c = '0;
    foreach (payload_buf[i]) begin
      c = crc_step(c, payload_buf[i]);
      push_byte((i == 0) ? 1'b0 : 1'($urandom_range(0, 1)), payload_buf[i], 1'b0);
    end
    if (corrupt) c = c ^ 16'($urandom_range(1, 65535));
    push_byte((payload_buf.size() == 0) ? 1'b0 : 1'($urandom_range(0, 1)), c[7:0], 1'b0);
    push_byte(1'($urandom_range(0, 1)), c[15:8], 1'b1);
  endtask

  // transmit frame: payload only, the block appends the CRC
  task automatic add_tx_frame();
    foreach (payload_buf[i])
      push_byte((i == 0) ? 1'b1 : 1'($urandom_range(0, 1)), payload_buf[i],
                (i == payload_buf.size() - 1));
  endtask

  // receive frame of random bytes, CRC almost surely wrong
  task automatic add_noise_frame(input int n);
    for (int i = 0; i < n; i++)
      push_byte((i == 0) ? 1'b0 : 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                (i == n - 1));
  endtask

  // Mostly well-formed frames with random content; short, noisy and
  // corrupted frames mixed in. Lengths mostly small, a few longer.
  task automatic add_random_frames(input int n_bytes);
    int made;
    int pick;
    int plen;
    made = 0;
    while (made < n_bytes) begin
      pick = $urandom_range(0, 99);
      plen = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
      if (pick < 6) begin
        push_byte(1'b0, 8'($urandom_range(0, 255)), 1'b1);
        made += 1;
      end else if (pick < 16) begin
        add_noise_frame(plen + 2);
        made += plen + 2;
      end else if (pick < 60) begin
        fill_payload(plen);
        add_rx_frame($urandom_range(0, 4) == 0);
        made += plen + 2;
      end else begin
        fill_payload(plen + 1);
        add_tx_frame();
        made += plen + 1;
      end
    end
  endtask

  // wait until everything sent has been answered, then let the pipe settle
  task automatic drain();
    do @(negedge clk);
    while (pending_bytes.size() != 0 || in_tvalid || expected_results.size() != 0);
    repeat (DrainCycles) @(negedge clk);
  endtask

  // register write, only ever issued with the block idle
  task automatic write_listening(input logic v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    listen_en = v;
    cfg_writes++;
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    foreach (status_seen[i]) status_seen[i] = 0;
    clear_frame();
    listen_en = 1'b1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    write_listening(1'b1);

    // directed: transmit extremes, short, good, bad and empty-payload frames
    payload_buf = {8'h00};
    add_tx_frame();
    payload_buf = {8'hFF, 8'hA5};
    add_tx_frame();
    push_byte(1'b0, 8'hFF, 1'b1);                 // one-byte receive: short
    payload_buf = {8'h31, 8'h32, 8'h33};
    add_rx_frame(1'b0);
    payload_buf = {8'h00, 8'hFF};
    add_rx_frame(1'b1);
    payload_buf.delete();
    add_rx_frame(1'b0);                           // CRC only, zero payload, good
    push_byte(1'b0, 8'h01, 1'b0);                 // two bytes, wrong CRC
    push_byte(1'b1, 8'h00, 1'b1);
    drain();

    // not listening: only a good CRC turns into the dropped status
    write_listening(1'b0);
    payload_buf = {8'h5A};
    add_rx_frame(1'b0);
    payload_buf.delete();
    add_rx_frame(1'b1);
    push_byte(1'b0, 8'h00, 1'b1);
    drain();

    // length limit: a receive frame one byte over the maximum
    write_listening(1'b1);
    fill_payload(cfae_pkg::MaxFrame - 1);
    add_rx_frame(1'b0);
    drain();

    // random phases, listening set before each: off, on, then random
    for (int p = 0; p < 4; p++) begin
      write_listening((p < 2) ? 1'(p) : 1'($urandom_range(0, 1)));
      add_random_frames(20);
      drain();
    end

    $display("Sent %0d bytes, checked %0d results, %0d register writes, %0d transmit frames.",
             bytes_sent, results_seen, cfg_writes, tx_frames);
    $display("Receive frames: good %0d, crc error %0d, short %0d, too long %0d, dropped %0d.",
             status_seen[cfae_pkg::ST_GOOD], status_seen[cfae_pkg::ST_CRC_ERROR],
             status_seen[cfae_pkg::ST_SHORT], status_seen[cfae_pkg::ST_TOO_LONG],
             status_seen[cfae_pkg::ST_NOT_LISTENING]);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
